>>> hdl/server_selector_with_session_hold_macros.svh
// Assertion macros for the server selector with session hold.
`ifndef SERVER_SELECTOR_WITH_SESSION_HOLD_MACROS_SVH
`define SERVER_SELECTOR_WITH_SESSION_HOLD_MACROS_SVH
`ifndef SYNTHESIS
// Checks that a condition implies another one in the same cycle.
`define SSH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("server selector check failed");
// Checks that a condition implies another one in the next cycle.
`define SSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("server selector check failed");
`else
`define SSH_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SSH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/ssh_pkg.sv
// Shared constants, codes and types of the server selector with session hold.
`default_nettype none
package ssh_pkg;
  localparam int SERVERS  = 8;
  localparam int SESSIONS = 64;
  localparam int SRV_IW   = $clog2(SERVERS);
  localparam int SRV_CW   = $clog2(SERVERS + 1);
  localparam int SESS_IW  = $clog2(SESSIONS);
  localparam int SESS_CW  = $clog2(SESSIONS + 1);

  localparam logic [2:0]  MISS_LIMIT    = 3'd4;
  localparam logic [2:0]  MISS_SAT      = 3'd7;
  localparam logic [15:0] TIMEOUT_RESET = 16'd30;
  localparam logic [31:0] SPEED_MAX     = 32'hFFFF_FFFF;

  localparam logic [1:0] M_REQUEST   = 2'd0;
  localparam logic [1:0] M_HEARTBEAT = 2'd1;
  localparam logic [1:0] M_ROUND_END = 2'd2;
  localparam logic [1:0] M_LOAD      = 2'd3;

  localparam logic [1:0] POL_WRR  = 2'd1;
  localparam logic [1:0] POL_FAST = 2'd2;

  localparam logic [1:0] HOLD_SRC = 2'd1;
  localparam logic [1:0] HOLD_USR = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SERVER = 2'd1;
  localparam logic [1:0] ST_HELD_GONE = 2'd2;
  localparam logic [1:0] ST_SESS_FULL = 2'd3;

  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_HOLD    = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    CMP_EQ,
    CMP_LT,
    CMP_AGE
  } cmp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SESS_RD,
    S_SESS_CMP,
    S_FIND,
    S_PICK,
    S_MIN,
    S_SESS_WR,
    S_COMPACT,
    S_EXP_RD,
    S_EXP_CMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] server;
    logic [31:0] stamp;
  } sess_word_t;
endpackage
`default_nettype wire

>>> hdl/ssh_ram.sv
// Generic RAM with one write port and one registered read port.
`default_nettype none
module ssh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hdl/ssh_cmp.sv
// Shared 32-bit compare unit: equality, less-than and session age test.
`default_nettype none
module ssh_cmp (
  input  wire ssh_pkg::cmp_op_t op,
  input  wire logic [31:0]      a,
  input  wire logic [31:0]      b,
  input  wire logic [15:0]      limit,
  output logic                  flag
);
  logic [31:0] diff;

  assign diff = a - b;

  always_comb begin
    unique case (op)
      ssh_pkg::CMP_EQ:  flag = (a == b);
      ssh_pkg::CMP_LT:  flag = (a < b);
      ssh_pkg::CMP_AGE: flag = (diff >= {16'd0, limit});
      default:          flag = 1'b0;
    endcase
  end
endmodule
`default_nettype wire

>>> hdl/server_selector_with_session_hold.sv
// Top level of the server selector with session hold.
// Usage: every request on the in_ channel (mode 0 request, 1 heartbeat outcome,
// 2 round end, 3 load server) yields exactly one result on the out_ channel.
// Both channels use valid/ready; the cfg_ port writes policy, hold mode and
// session timeout with cfg_we, cfg_index and cfg_wdata. The user is to write it
// only while the block is idle; the block itself does not enforce this.
// A request is worked on alone under a small sequencer that drives one shared
// 32-bit compare unit and a 64-entry session RAM with a registered read.
// Load and heartbeat are done in the dispatch state. In a request, the session
// search compares each valid entry and skips each empty one; the server id
// search and the fastest response search step over the servers. A round end
// compacts the server table and then sweeps the session RAM for expiry.
// in_ready is high only while the sequencer is idle; a finished result sits in
// the output register, so the next request is taken while it waits for out_ready.
// If the receiver stalls with a result still held, the next finished result
// waits in the done state until the output register frees up.
// Reset (rst_n low at a clock edge) empties the server table, drops all
// sessions through their valid bits and restores the register defaults.
`default_nettype none
module server_selector_with_session_hold (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_client_source,
  input  wire logic [31:0] in_client_user,
  input  wire logic [31:0] in_now_seconds,
  input  wire logic [2:0]  in_server_index,
  input  wire logic        in_ack_received,
  input  wire logic [31:0] in_response_time,
  input  wire logic [31:0] in_server_id,
  input  wire logic [3:0]  in_server_weight,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [2:0]       out_chosen_index,
  output logic [31:0]      out_chosen_id,
  output logic [3:0]       out_live_servers,
  output logic [6:0]       out_live_sessions,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);
  `include "server_selector_with_session_hold_macros.svh"

  localparam int SRV_IW  = ssh_pkg::SRV_IW;
  localparam int SRV_CW  = ssh_pkg::SRV_CW;
  localparam int SESS_IW = ssh_pkg::SESS_IW;
  localparam int SESS_CW = ssh_pkg::SESS_CW;

  // Configuration registers.
  logic [1:0]  policy_r;
  logic [1:0]  hold_mode_r;
  logic [15:0] timeout_r;

  // Sequencer state.
  ssh_pkg::state_t state_r, state_nxt;

  // Captured request fields.
  logic [1:0]        mode_r;
  logic [31:0]       key_r;
  logic [31:0]       now_r;
  logic [2:0]        hidx_r;
  logic              ack_r;
  logic [31:0]       rtt_r;
  logic [31:0]       sid_r;
  logic [3:0]        swt_r;

  // Server table, held in flip-flops.
  logic [31:0] srv_id_r    [ssh_pkg::SERVERS];
  logic [31:0] srv_id_nxt  [ssh_pkg::SERVERS];
  logic [3:0]  srv_wt_r    [ssh_pkg::SERVERS];
  logic [3:0]  srv_wt_nxt  [ssh_pkg::SERVERS];
  logic [31:0] srv_spd_r   [ssh_pkg::SERVERS];
  logic [31:0] srv_spd_nxt [ssh_pkg::SERVERS];
  logic [2:0]  srv_mis_r   [ssh_pkg::SERVERS];
  logic [2:0]  srv_mis_nxt [ssh_pkg::SERVERS];
  logic [SRV_CW-1:0] srv_cnt_r, srv_cnt_nxt;
  logic [SRV_IW-1:0] rr_ptr_r, rr_ptr_nxt;
  logic [3:0]        wleft_r, wleft_nxt;
  logic              wstart_r, wstart_nxt;

  // Session bookkeeping; keys, servers and stamps live in the RAM.
  logic [ssh_pkg::SESSIONS-1:0] sess_valid_r, sess_valid_nxt;
  logic [SESS_CW-1:0] sess_cnt_r, sess_cnt_nxt;

  // Iterators and search results.
  logic [SESS_CW-1:0] idx_r, idx_nxt;
  logic [SRV_CW-1:0]  sidx_r, sidx_nxt;
  logic [SRV_CW-1:0]  wptr_r, wptr_nxt;
  logic [SRV_IW-1:0]  best_r, best_nxt;
  logic [SESS_IW-1:0] free_r, free_nxt;
  logic               free_found_r, free_found_nxt;
  logic [31:0]        held_r, held_nxt;

  // Result being built and the output register.
  logic [1:0]        res_status_r, res_status_nxt;
  logic [SRV_IW-1:0] res_idx_r, res_idx_nxt;
  logic [31:0]       res_id_r, res_id_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r;
  logic [2:0]        out_index_r;
  logic [31:0]       out_id_r;
  logic [3:0]        out_srv_r;
  logic [6:0]        out_sess_r;

  // Shared compare unit and session RAM.
  ssh_pkg::cmp_op_t   cmp_op;
  logic [31:0]        cmp_a;
  logic [31:0]        cmp_b;
  logic               cmp_flag;
  logic               ram_we;
  logic [SESS_IW-1:0] ram_waddr;
  ssh_pkg::sess_word_t ram_wdata;
  ssh_pkg::sess_word_t ram_rdata;

  logic in_fire;
  logic out_free;
  logic hold_on;
  logic srv_end;
  logic sess_end;
  logic cur_valid;
  logic [SRV_IW-1:0]  sidx_i;
  logic [SESS_IW-1:0] idx_i;

  // A pointer at or past the end of the table wraps to the first entry.
  function automatic logic [SRV_IW-1:0] wrap_ptr(input logic [SRV_CW-1:0] p,
                                                 input logic [SRV_CW-1:0] cnt);
    logic [SRV_IW-1:0] r;
    r = (p >= cnt) ? '0 : p[SRV_IW-1:0];
    return r;
  endfunction

  assign in_ready  = (state_r == ssh_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign hold_on   = (hold_mode_r == ssh_pkg::HOLD_SRC) ||
                     (hold_mode_r == ssh_pkg::HOLD_USR);
  assign srv_end   = (sidx_r >= srv_cnt_r);
  assign sess_end  = (idx_r == SESS_CW'(ssh_pkg::SESSIONS));
  assign sidx_i    = sidx_r[SRV_IW-1:0];
  assign idx_i     = idx_r[SESS_IW-1:0];
  assign cur_valid = sess_valid_r[idx_i];

  ssh_cmp u_cmp (
    .op    (cmp_op),
    .a     (cmp_a),
    .b     (cmp_b),
    .limit (timeout_r),
    .flag  (cmp_flag)
  );

  ssh_ram #(
    .WIDTH ($bits(ssh_pkg::sess_word_t)),
    .DEPTH (ssh_pkg::SESSIONS)
  ) u_sess_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_i),
    .rdata (ram_rdata)
  );

  // The compare unit is steered by the state that owns it this cycle.
  always_comb begin
    unique case (state_r)
      ssh_pkg::S_SESS_CMP: begin
        cmp_op = ssh_pkg::CMP_EQ;
        cmp_a  = key_r;
        cmp_b  = ram_rdata.key;
      end
      ssh_pkg::S_FIND: begin
        cmp_op = ssh_pkg::CMP_EQ;
        cmp_a  = srv_id_r[sidx_i];
        cmp_b  = held_r;
      end
      ssh_pkg::S_MIN: begin
        cmp_op = ssh_pkg::CMP_LT;
        cmp_a  = srv_spd_r[sidx_i];
        cmp_b  = srv_spd_r[best_r];
      end
      ssh_pkg::S_EXP_CMP: begin
        cmp_op = ssh_pkg::CMP_AGE;
        cmp_a  = now_r;
        cmp_b  = ram_rdata.stamp;
      end
      default: begin
        cmp_op = ssh_pkg::CMP_EQ;
        cmp_a  = '0;
        cmp_b  = '0;
      end
    endcase
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssh_pkg::S_IDLE: begin
        if (in_fire) state_nxt = ssh_pkg::S_DISPATCH;
      end
      ssh_pkg::S_DISPATCH: begin
        unique case (mode_r)
          ssh_pkg::M_REQUEST: begin
            if (srv_cnt_r == '0) state_nxt = ssh_pkg::S_DONE;
            else if (hold_on)    state_nxt = ssh_pkg::S_SESS_RD;
            else                 state_nxt = ssh_pkg::S_PICK;
          end
          ssh_pkg::M_ROUND_END: state_nxt = ssh_pkg::S_COMPACT;
          default:              state_nxt = ssh_pkg::S_DONE;
        endcase
      end
      ssh_pkg::S_SESS_RD: begin
        if (sess_end)       state_nxt = ssh_pkg::S_PICK;
        else if (cur_valid) state_nxt = ssh_pkg::S_SESS_CMP;
      end
      ssh_pkg::S_SESS_CMP: begin
        state_nxt = cmp_flag ? ssh_pkg::S_FIND : ssh_pkg::S_SESS_RD;
      end
      ssh_pkg::S_FIND: begin
        if (srv_end || cmp_flag) state_nxt = ssh_pkg::S_DONE;
      end
      ssh_pkg::S_PICK: begin
        if (policy_r == ssh_pkg::POL_FAST) state_nxt = ssh_pkg::S_MIN;
        else if (hold_on)                  state_nxt = ssh_pkg::S_SESS_WR;
        else                               state_nxt = ssh_pkg::S_DONE;
      end
      ssh_pkg::S_MIN: begin
        if (srv_end) state_nxt = hold_on ? ssh_pkg::S_SESS_WR : ssh_pkg::S_DONE;
      end
      ssh_pkg::S_SESS_WR: state_nxt = ssh_pkg::S_DONE;
      ssh_pkg::S_COMPACT: begin
        if (srv_end) state_nxt = ssh_pkg::S_EXP_RD;
      end
      ssh_pkg::S_EXP_RD: begin
        if (sess_end)       state_nxt = ssh_pkg::S_DONE;
        else if (cur_valid) state_nxt = ssh_pkg::S_EXP_CMP;
      end
      ssh_pkg::S_EXP_CMP: state_nxt = ssh_pkg::S_EXP_RD;
      ssh_pkg::S_DONE: begin
        if (out_free) state_nxt = ssh_pkg::S_IDLE;
      end
      default: state_nxt = ssh_pkg::S_IDLE;
    endcase
  end

  // Datapath updates of each state.
  always_comb begin
    logic [SRV_IW-1:0] p;
    logic [3:0]        wl;
    srv_id_nxt     = srv_id_r;
    srv_wt_nxt     = srv_wt_r;
    srv_spd_nxt    = srv_spd_r;
    srv_mis_nxt    = srv_mis_r;
    srv_cnt_nxt    = srv_cnt_r;
    rr_ptr_nxt     = rr_ptr_r;
    wleft_nxt      = wleft_r;
    wstart_nxt     = wstart_r;
    sess_valid_nxt = sess_valid_r;
    sess_cnt_nxt   = sess_cnt_r;
    idx_nxt        = idx_r;
    sidx_nxt       = sidx_r;
    wptr_nxt       = wptr_r;
    best_nxt       = best_r;
    free_nxt       = free_r;
    free_found_nxt = free_found_r;
    held_nxt       = held_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_id_nxt     = res_id_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_i;
    ram_wdata      = ram_rdata;
    p              = '0;
    wl             = '0;
    unique case (state_r)
      ssh_pkg::S_DISPATCH: begin
        res_status_nxt = ssh_pkg::ST_OK;
        res_idx_nxt    = '0;
        res_id_nxt     = '0;
        idx_nxt        = '0;
        sidx_nxt       = '0;
        wptr_nxt       = '0;
        free_found_nxt = 1'b0;
        unique case (mode_r)
          ssh_pkg::M_REQUEST: begin
            if (srv_cnt_r == '0) res_status_nxt = ssh_pkg::ST_NO_SERVER;
          end
          ssh_pkg::M_HEARTBEAT: begin
            if (SRV_CW'(hidx_r) < srv_cnt_r) begin
              if (ack_r) begin
                srv_spd_nxt[hidx_r[SRV_IW-1:0]] = rtt_r;
                srv_mis_nxt[hidx_r[SRV_IW-1:0]] = '0;
              end else begin
                if (srv_mis_r[hidx_r[SRV_IW-1:0]] < ssh_pkg::MISS_SAT) begin
                  srv_mis_nxt[hidx_r[SRV_IW-1:0]] = srv_mis_r[hidx_r[SRV_IW-1:0]] + 3'd1;
                end
                // Doubling saturates once the top bit is set.
                srv_spd_nxt[hidx_r[SRV_IW-1:0]] = srv_spd_r[hidx_r[SRV_IW-1:0]][31]
                    ? ssh_pkg::SPEED_MAX : {srv_spd_r[hidx_r[SRV_IW-1:0]][30:0], 1'b0};
              end
            end
          end
          ssh_pkg::M_LOAD: begin
            if (srv_cnt_r < SRV_CW'(ssh_pkg::SERVERS)) begin
              srv_id_nxt[srv_cnt_r[SRV_IW-1:0]]  = sid_r;
              srv_wt_nxt[srv_cnt_r[SRV_IW-1:0]]  = (swt_r == 4'd0) ? 4'd1 : swt_r;
              srv_spd_nxt[srv_cnt_r[SRV_IW-1:0]] = ssh_pkg::SPEED_MAX;
              srv_mis_nxt[srv_cnt_r[SRV_IW-1:0]] = '0;
              srv_cnt_nxt = srv_cnt_r + SRV_CW'(1);
            end
          end
          default: ;
        endcase
      end
      ssh_pkg::S_SESS_RD: begin
        if (!sess_end && !cur_valid) begin
          if (!free_found_r) begin
            free_nxt       = idx_i;
            free_found_nxt = 1'b1;
          end
          idx_nxt = idx_r + SESS_CW'(1);
        end
      end
      ssh_pkg::S_SESS_CMP: begin
        if (cmp_flag) begin
          // Hit: refresh the stamp and look the held server up by id.
          ram_we          = 1'b1;
          ram_waddr       = idx_i;
          ram_wdata       = ram_rdata;
          ram_wdata.stamp = now_r;
          held_nxt        = ram_rdata.server;
          sidx_nxt        = '0;
        end else begin
          idx_nxt = idx_r + SESS_CW'(1);
        end
      end
      ssh_pkg::S_FIND: begin
        if (srv_end) begin
          res_status_nxt = ssh_pkg::ST_HELD_GONE;
        end else if (cmp_flag) begin
          res_idx_nxt = sidx_i;
          res_id_nxt  = srv_id_r[sidx_i];
        end else begin
          sidx_nxt = sidx_r + SRV_CW'(1);
        end
      end
      ssh_pkg::S_PICK: begin
        if (policy_r == ssh_pkg::POL_FAST) begin
          best_nxt = '0;
          sidx_nxt = SRV_CW'(1);
        end else if (policy_r == ssh_pkg::POL_WRR) begin
          p  = wrap_ptr(SRV_CW'(rr_ptr_r), srv_cnt_r);
          wl = wleft_r;
          if (!wstart_r) begin
            wl         = srv_wt_r[p];
            wstart_nxt = 1'b1;
          end else if (p != rr_ptr_r) begin
            wl = srv_wt_r[p];
          end else if (wl == 4'd0) begin
            p  = wrap_ptr(SRV_CW'(p) + SRV_CW'(1), srv_cnt_r);
            wl = srv_wt_r[p];
          end
          rr_ptr_nxt = p;
          if (wl != 4'd0) wl = wl - 4'd1;
          wleft_nxt   = wl;
          res_idx_nxt = p;
          res_id_nxt  = srv_id_r[p];
        end else begin
          p           = wrap_ptr(SRV_CW'(rr_ptr_r), srv_cnt_r);
          rr_ptr_nxt  = wrap_ptr(SRV_CW'(p) + SRV_CW'(1), srv_cnt_r);
          res_idx_nxt = p;
          res_id_nxt  = srv_id_r[p];
        end
      end
      ssh_pkg::S_MIN: begin
        if (srv_end) begin
          res_idx_nxt = best_r;
          res_id_nxt  = srv_id_r[best_r];
        end else begin
          if (cmp_flag) best_nxt = sidx_i;
          sidx_nxt = sidx_r + SRV_CW'(1);
        end
      end
      ssh_pkg::S_SESS_WR: begin
        if (free_found_r) begin
          ram_we               = 1'b1;
          ram_waddr            = free_r;
          ram_wdata.key        = key_r;
          ram_wdata.server     = res_id_r;
          ram_wdata.stamp      = now_r;
          sess_valid_nxt[free_r] = 1'b1;
          sess_cnt_nxt         = sess_cnt_r + SESS_CW'(1);
        end else begin
          res_status_nxt = ssh_pkg::ST_SESS_FULL;
        end
      end
      ssh_pkg::S_COMPACT: begin
        if (srv_end) begin
          srv_cnt_nxt = wptr_r;
          idx_nxt     = '0;
        end else begin
          if (srv_mis_r[sidx_i] < ssh_pkg::MISS_LIMIT) begin
            srv_id_nxt[wptr_r[SRV_IW-1:0]]  = srv_id_r[sidx_i];
            srv_wt_nxt[wptr_r[SRV_IW-1:0]]  = srv_wt_r[sidx_i];
            srv_spd_nxt[wptr_r[SRV_IW-1:0]] = srv_spd_r[sidx_i];
            srv_mis_nxt[wptr_r[SRV_IW-1:0]] = srv_mis_r[sidx_i];
            wptr_nxt = wptr_r + SRV_CW'(1);
          end
          sidx_nxt = sidx_r + SRV_CW'(1);
        end
      end
      ssh_pkg::S_EXP_RD: begin
        if (!sess_end && !cur_valid) idx_nxt = idx_r + SESS_CW'(1);
      end
      ssh_pkg::S_EXP_CMP: begin
        if (cmp_flag) begin
          sess_valid_nxt[idx_i] = 1'b0;
          sess_cnt_nxt          = sess_cnt_r - SESS_CW'(1);
        end
        idx_nxt = idx_r + SESS_CW'(1);
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = (state_r == ssh_pkg::S_DONE && out_free) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ssh_pkg::S_IDLE;
      policy_r     <= '0;
      hold_mode_r  <= '0;
      timeout_r    <= ssh_pkg::TIMEOUT_RESET;
      srv_cnt_r    <= '0;
      rr_ptr_r     <= '0;
      wleft_r      <= '0;
      wstart_r     <= 1'b0;
      sess_valid_r <= '0;
      sess_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      srv_cnt_r    <= srv_cnt_nxt;
      rr_ptr_r     <= rr_ptr_nxt;
      wleft_r      <= wleft_nxt;
      wstart_r     <= wstart_nxt;
      sess_valid_r <= sess_valid_nxt;
      sess_cnt_r   <= sess_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ssh_pkg::CFG_POLICY:  policy_r    <= cfg_wdata[1:0];
          ssh_pkg::CFG_HOLD:    hold_mode_r <= cfg_wdata[1:0];
          ssh_pkg::CFG_TIMEOUT: timeout_r   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    srv_id_r     <= srv_id_nxt;
    srv_wt_r     <= srv_wt_nxt;
    srv_spd_r    <= srv_spd_nxt;
    srv_mis_r    <= srv_mis_nxt;
    idx_r        <= idx_nxt;
    sidx_r       <= sidx_nxt;
    wptr_r       <= wptr_nxt;
    best_r       <= best_nxt;
    free_r       <= free_nxt;
    free_found_r <= free_found_nxt;
    held_r       <= held_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_id_r     <= res_id_nxt;
    if (in_fire) begin
      mode_r <= in_mode;
      key_r  <= (hold_mode_r == ssh_pkg::HOLD_SRC) ? in_client_source : in_client_user;
      now_r  <= in_now_seconds;
      hidx_r <= in_server_index;
      ack_r  <= in_ack_received;
      rtt_r  <= in_response_time;
      sid_r  <= in_server_id;
      swt_r  <= in_server_weight;
    end
    if (state_r == ssh_pkg::S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_index_r  <= 3'(res_idx_r);
      out_id_r     <= res_id_r;
      out_srv_r    <= 4'(srv_cnt_r);
      out_sess_r   <= 7'(sess_cnt_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_chosen_index  = out_index_r;
  assign out_chosen_id     = out_id_r;
  assign out_live_servers  = out_srv_r;
  assign out_live_sessions = out_sess_r;

  // The session counter tracks the valid bits exactly.
  `SSH_ASSERT_NOW(a_sess_cnt, clk, rst_n, 1'b1, sess_cnt_r == SESS_CW'($countones(sess_valid_r)))
  // The server table never grows past its capacity.
  `SSH_ASSERT_NOW(a_srv_cnt, clk, rst_n, 1'b1, srv_cnt_r <= SRV_CW'(ssh_pkg::SERVERS))
  // Leaving the done state always presents a result.
  `SSH_ASSERT_NEXT(a_done_out, clk, rst_n, state_r == ssh_pkg::S_DONE && out_free, out_valid_r)
  // A new request is only taken with the sequencer back in idle.
  `SSH_ASSERT_NEXT(a_accept, clk, rst_n, in_fire, state_r == ssh_pkg::S_DISPATCH)
endmodule
`default_nettype wire
